// File: hw/rtl/srt_pkg.sv
// Shared types and constants of the sample rate throttle.
package srt_pkg;

    localparam int BLOCK_W   = 32;
    localparam int PERIOD_W  = 32;
    localparam int LATE_W    = 40;
    localparam int TIME_W    = 64;
    localparam int AMOUNT_W  = 32;
    localparam int CREDIT_W  = 64;
    localparam int WAIT_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Catch-up periods are the quotient of an elapsed time below the late limit.
    localparam int DIV_STEPS = LATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int PROD_W    = LATE_W + BLOCK_W;

    localparam logic [BLOCK_W-1:0]  BLOCK_RESET  = 32'd1024;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000000;
    localparam logic [LATE_W-1:0]   LATE_RESET   = 40'd100000000;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATE_LIMIT_NS = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_IN_PERIOD   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFILL_WAIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CAUGHT_UP   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_LATE_RESET  = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ELAPSED,
        OP_CONSUME,
        OP_HOLD,
        OP_REFILL,
        OP_CATCH_NONE,
        OP_LATE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_APPLY,
        OP_ADVANCE,
        OP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        logic func;
        logic in_period;
        logic credit_zero;
        logic below_late;
        logic period_zero;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/srt_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module srt_ctrl
    import srt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ELAPSED = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_DIVIDE  = 7'b0001000,
        S_APPLY   = 7'b0010000,
        S_ADVANCE = 7'b0100000,
        S_OUTPUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_ELAPSED;
                end
            end
            S_ELAPSED:
            begin
                op         = OP_ELAPSED;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_OUTPUT;
                if (stat.func)
                begin
                    op = OP_CONSUME;
                end
                else if (stat.in_period)
                begin
                    op = stat.credit_zero ? OP_REFILL : OP_HOLD;
                end
                else if (stat.below_late)
                begin
                    if (stat.period_zero)
                    begin
                        op = OP_CATCH_NONE;
                    end
                    else
                    begin
                        op         = OP_DIV_START;
                        state_next = S_DIVIDE;
                    end
                end
                else
                begin
                    op = OP_LATE;
                end
            end
            S_DIVIDE:
            begin
                op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                op         = OP_APPLY;
                state_next = S_ADVANCE;
            end
            S_ADVANCE:
            begin
                op         = OP_ADVANCE;
                state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (stat.out_free)
                begin
                    op         = OP_OUTPUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/srt_dp.sv
// Datapath: configuration, period and credit state, divider and result register.
module srt_dp
    import srt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_op_t               op,
    output dp_stat_t             stat,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LATE_W-1:0]    cfg_data,
    input  logic                 in_func,
    input  logic [TIME_W-1:0]    in_now,
    input  logic [AMOUNT_W-1:0]  in_amount,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [AMOUNT_W-1:0]  out_granted,
    output logic [WAIT_W-1:0]    out_wait,
    output logic [STATUS_W-1:0]  out_status
);

    // Control state, cleared by reset.
    logic [BLOCK_W-1:0]   block_reg,        block_next;
    logic [PERIOD_W-1:0]  period_reg,       period_next;
    logic [LATE_W-1:0]    late_reg,         late_next;
    logic [TIME_W-1:0]    period_start_reg, period_start_next;
    logic [CREDIT_W-1:0]  credit_reg,       credit_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,      div_cnt_next;
    logic                 out_valid_reg,    out_valid_next;

    // Payload registers.
    logic                 func_reg,        func_next;
    logic [TIME_W-1:0]    now_reg,         now_next;
    logic [AMOUNT_W-1:0]  amount_reg,      amount_next;
    logic [TIME_W-1:0]    elapsed_reg,     elapsed_next;
    logic [LATE_W-1:0]    dvd_reg,         dvd_next;
    logic [PERIOD_W-1:0]  rem_reg,         rem_next;
    logic [PROD_W-1:0]    prod_reg,        prod_next;
    logic [LATE_W-1:0]    step_reg,        step_next;
    logic [WAIT_W-1:0]    wait_reg,        wait_next;
    logic [STATUS_W-1:0]  status_reg,      status_next;
    logic [AMOUNT_W-1:0]  out_granted_reg, out_granted_next;
    logic [WAIT_W-1:0]    out_wait_reg,    out_wait_next;
    logic [STATUS_W-1:0]  out_status_reg,  out_status_next;

    logic [PERIOD_W:0]     div_shift;
    logic                  div_ge;
    logic [CREDIT_W+PROD_W-CREDIT_W+8:0] credit_sum;
    logic [CREDIT_W-1:0]   credit_sat;
    logic                  amount_covers;
    logic [AMOUNT_W-1:0]   grant_val;

    assign stat.func        = func_reg;
    assign stat.in_period   = (elapsed_reg < {{(TIME_W-PERIOD_W){1'b0}}, period_reg});
    assign stat.credit_zero = (credit_reg == '0);
    assign stat.below_late  = (elapsed_reg < {{(TIME_W-LATE_W){1'b0}}, late_reg});
    assign stat.period_zero = (period_reg == '0);
    assign stat.div_last    = (div_cnt_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // One quotient bit per cycle; the quotient bit also drives the shift-add
    // product of skipped periods times the refill size.
    assign div_shift = {rem_reg, dvd_reg[LATE_W-1]};
    assign div_ge    = (div_shift >= {1'b0, period_reg});

    // The credit plus all refills saturates when it leaves 64 bits.
    assign credit_sum = {{(PROD_W-CREDIT_W+9){1'b0}}, credit_reg}
                      + {9'b0, prod_reg};
    assign credit_sat = (|credit_sum[$high(credit_sum):CREDIT_W]) ? '1
                                                                   : credit_sum[CREDIT_W-1:0];

    // When the amount covers the credit, the credit fits in 32 bits.
    assign amount_covers = ({{(CREDIT_W-AMOUNT_W){1'b0}}, amount_reg} >= credit_reg);
    assign grant_val     = func_reg      ? '0 :
                           amount_covers ? credit_reg[AMOUNT_W-1:0] : amount_reg;

    always_comb
    begin
        block_next        = block_reg;
        period_next       = period_reg;
        late_next         = late_reg;
        period_start_next = period_start_reg;
        credit_next       = credit_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        func_next         = func_reg;
        now_next          = now_reg;
        amount_next       = amount_reg;
        elapsed_next      = elapsed_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        prod_next         = prod_reg;
        step_next         = step_reg;
        wait_next         = wait_reg;
        status_next       = status_reg;
        out_granted_next  = out_granted_reg;
        out_wait_next     = out_wait_reg;
        out_status_next   = out_status_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_BLOCK_SAMPLES: block_next  = cfg_data[BLOCK_W-1:0];
                REG_PERIOD_NS:     period_next = cfg_data[PERIOD_W-1:0];
                REG_LATE_LIMIT_NS: late_next   = cfg_data;
                default:           ;
            endcase
        end

        case (op)
            OP_LOAD:
            begin
                func_next   = in_func;
                now_next    = in_now;
                amount_next = in_amount;
            end
            OP_ELAPSED:
            begin
                elapsed_next = now_reg - period_start_reg;
            end
            OP_CONSUME:
            begin
                credit_next = amount_covers ? '0
                            : credit_reg - {{(CREDIT_W-AMOUNT_W){1'b0}}, amount_reg};
                wait_next   = '0;
                status_next = STAT_IN_PERIOD;
            end
            OP_HOLD:
            begin
                wait_next   = '0;
                status_next = STAT_IN_PERIOD;
            end
            OP_REFILL:
            begin
                period_start_next = period_start_reg
                                  + {{(TIME_W-PERIOD_W){1'b0}}, period_reg};
                credit_next       = {{(CREDIT_W-BLOCK_W){1'b0}}, block_reg};
                wait_next         = period_reg - elapsed_reg[WAIT_W-1:0];
                status_next       = STAT_REFILL_WAIT;
            end
            OP_CATCH_NONE:
            begin
                wait_next   = '0;
                status_next = STAT_CAUGHT_UP;
            end
            OP_LATE:
            begin
                period_start_next = now_reg;
                credit_next       = {{(CREDIT_W-BLOCK_W){1'b0}}, block_reg};
                wait_next         = '0;
                status_next       = STAT_LATE_RESET;
            end
            OP_DIV_START:
            begin
                dvd_next     = elapsed_reg[LATE_W-1:0];
                rem_next     = '0;
                prod_next    = '0;
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                wait_next    = '0;
                status_next  = STAT_CAUGHT_UP;
            end
            OP_DIV_STEP:
            begin
                dvd_next     = {dvd_reg[LATE_W-2:0], 1'b0};
                rem_next     = div_ge ? PERIOD_W'(div_shift - {1'b0, period_reg})
                                      : div_shift[PERIOD_W-1:0];
                prod_next    = {prod_reg[PROD_W-2:0], 1'b0}
                             + (div_ge ? {{(PROD_W-BLOCK_W){1'b0}}, block_reg} : '0);
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            OP_APPLY:
            begin
                // Whole periods advanced: elapsed time less the remainder.
                step_next   = elapsed_reg[LATE_W-1:0] - {{(LATE_W-PERIOD_W){1'b0}}, rem_reg};
                credit_next = credit_sat;
            end
            OP_ADVANCE:
            begin
                period_start_next = period_start_reg + {{(TIME_W-LATE_W){1'b0}}, step_reg};
            end
            OP_OUTPUT:
            begin
                out_valid_next   = 1'b1;
                out_granted_next = grant_val;
                out_wait_next    = wait_reg;
                out_status_next  = status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg        <= BLOCK_RESET;
            period_reg       <= PERIOD_RESET;
            late_reg         <= LATE_RESET;
            period_start_reg <= '0;
            credit_reg       <= {{(CREDIT_W-BLOCK_W){1'b0}}, BLOCK_RESET};
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            block_reg        <= block_next;
            period_reg       <= period_next;
            late_reg         <= late_next;
            period_start_reg <= period_start_next;
            credit_reg       <= credit_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        now_reg         <= now_next;
        amount_reg      <= amount_next;
        elapsed_reg     <= elapsed_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        prod_reg        <= prod_next;
        step_reg        <= step_next;
        wait_reg        <= wait_next;
        status_reg      <= status_next;
        out_granted_reg <= out_granted_next;
        out_wait_reg    <= out_wait_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_wait    = out_wait_reg;
    assign out_status  = out_status_reg;

endmodule

// File: hw/rtl/sample_rate_throttle_top.sv
// Sample rate throttle top level: stream ports, configuration port, controller and datapath.
//
// Credit-based sample throttle. Each input beat is either a request (tuser 0),
// carrying the current time in ns and the samples wanted, or a consume (tuser 1),
// carrying the samples used. Every input beat yields exactly one output beat with
// the samples granted, the wait time and a status code. The block works on one
// item at a time: a consume or a request that stays in its period, refills with
// wait, or resets late goes through the elapsed and decide states to output; a
// request that catches up over whole periods also runs the 40-step restoring
// divider, which counts the elapsed periods one quotient bit per cycle.
// A finished output beat waits in the output register while the next input beat
// is taken. Configuration writes are always accepted (cfg_ready is tied high) and
// must be issued only while the block is idle.
module sample_rate_throttle_top
    import srt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [95:0]          s_axis_tdata,   // now_ns [63:0], amount [95:64]
    input  logic                 s_axis_tuser,   // func [0]

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // granted [31:0], wait_ns [63:32]
    output logic [STATUS_W-1:0]  m_axis_tuser,   // status [1:0]

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LATE_W-1:0]    cfg_data
);

    dp_op_t               op;
    dp_stat_t             stat;
    logic [AMOUNT_W-1:0]  granted;
    logic [WAIT_W-1:0]    wait_ns;

    assign cfg_ready = 1'b1;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .op       (op)
    );

    srt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stat        (stat),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_func     (s_axis_tuser),
        .in_now      (s_axis_tdata[TIME_W-1:0]),
        .in_amount   (s_axis_tdata[TIME_W+AMOUNT_W-1:TIME_W]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_granted (granted),
        .out_wait    (wait_ns),
        .out_status  (m_axis_tuser)
    );

    assign m_axis_tdata = {wait_ns, granted};

endmodule

// File: hw/rtl/srt_checker.sv
// Port-level assertions for the sample rate throttle and their bind.
module srt_checker
    import srt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [63:0]          m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    // A wait time is reported exactly when the credit was refilled with a wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == STAT_REFILL_WAIT) == (m_axis_tdata[63:32] != '0)))
        else $error("wait_ns does not match the refill status");

    // Only one item is in work: after an input beat the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an input beat");

    // An input beat cannot produce a result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared one cycle after its input beat");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output beat changed");

endmodule

bind sample_rate_throttle_top srt_checker u_srt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tb_sample_rate_throttle_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the sample rate throttle top level.
module tb_sample_rate_throttle_top
    import srt_pkg::*;
();

    localparam logic                 FUNC_REQUEST     = 1'b0;
    localparam logic                 FUNC_CONSUME     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 2'd3;
    localparam int                   WATCHDOG_LIMIT   = 2000;
    localparam int                   DRAIN_CYCLES     = 60;
    localparam int                   RANDOM_PER_PHASE = 88;

    typedef struct {
        logic                func;
        logic [TIME_W-1:0]   now_ns;
        logic [AMOUNT_W-1:0] amount;
    } sample_req_t;

    typedef struct {
        logic [AMOUNT_W-1:0] granted;
        logic [WAIT_W-1:0]   wait_ns;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [95:0]          s_axis_tdata  = '0;   // now_ns [63:0], amount [95:64]
    logic                 s_axis_tuser  = 1'b0; // func [0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;         // granted [31:0], wait_ns [63:32]
    logic [STATUS_W-1:0]  m_axis_tuser;         // status [1:0]
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LATE_W-1:0]    cfg_data      = '0;

    // Throttle state and register copies used for prediction.
    logic [TIME_W-1:0]    pred_period_start = '0;
    logic [CREDIT_W-1:0]  pred_credit       = CREDIT_W'(BLOCK_RESET);
    logic [BLOCK_W-1:0]   pred_block        = BLOCK_RESET;
    logic [PERIOD_W-1:0]  pred_period       = PERIOD_RESET;
    logic [LATE_W-1:0]    pred_late         = LATE_RESET;

    sample_req_t          req_q[$];
    grant_t               grant_q[$];
    logic [TIME_W-1:0]    stim_now = '0;
    int                   send_idle_pct  = 0;
    int                   sink_stall_pct = 0;
    int                   error_count    = 0;
    int                   quiet_cycles   = 0;

    sample_rate_throttle_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Advances the throttle state by one item and returns the grant it produces.
    function automatic grant_t predict_grant(input sample_req_t req);
        grant_t              g;
        logic [TIME_W-1:0]   elapsed;
        logic [TIME_W-1:0]   skipped;
        logic [CREDIT_W-1:0] room;
        g.granted = '0;
        g.wait_ns = '0;
        g.status  = STAT_IN_PERIOD;
        if (req.func == FUNC_CONSUME)
        begin
            if (CREDIT_W'(req.amount) < pred_credit)
                pred_credit -= req.amount;
            else
                pred_credit = '0;
        end
        else
        begin
            elapsed = req.now_ns - pred_period_start;
            if (elapsed < TIME_W'(pred_period))
            begin
                if (pred_credit == '0)
                begin
                    pred_period_start += pred_period;
                    pred_credit = CREDIT_W'(pred_block);
                    g.wait_ns   = WAIT_W'(TIME_W'(pred_period) - elapsed);
                    g.status    = STAT_REFILL_WAIT;
                end
            end
            else if (elapsed < TIME_W'(pred_late))
            begin
                skipped = (pred_period != '0) ? elapsed / pred_period : '0;
                pred_period_start += skipped * pred_period;
                if (pred_block != '0 && skipped != '0)
                begin
                    room = '1 - pred_credit;
                    // The refill saturates rather than wrapping.
                    if (skipped > room / pred_block)
                        pred_credit = '1;
                    else
                        pred_credit += skipped * pred_block;
                end
                g.status = STAT_CAUGHT_UP;
            end
            else
            begin
                pred_period_start = req.now_ns;
                pred_credit       = CREDIT_W'(pred_block);
                g.status          = STAT_LATE_RESET;
            end
            g.granted = (CREDIT_W'(req.amount) < pred_credit) ? req.amount
                                                               : AMOUNT_W'(pred_credit);
        end
        return g;
    endfunction

    // Mostly forward-moving time around period and late-limit boundaries, with some noise.
    function automatic sample_req_t next_random_req();
        sample_req_t       r;
        int unsigned       pick;
        logic [TIME_W-1:0] span;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            r.func   = 1'($urandom_range(1));
            r.now_ns = {$urandom, $urandom};
            r.amount = $urandom;
            return r;
        end
        r.func = (pick < 40) ? FUNC_CONSUME : FUNC_REQUEST;
        pick = $urandom_range(99);
        if (pick < 15)
            r.amount = '1;
        else if (pick < 25)
            r.amount = '0;
        else if (pick < 45)
            r.amount = $urandom;
        else
            r.amount = $urandom_range(1, 64);
        span = (pred_period == '0) ? 64'd4 : TIME_W'(pred_period);
        pick = $urandom_range(99);
        if (pick < 40)
            stim_now += TIME_W'($urandom) % (span / 2 + 1);
        else if (pick < 62)
            stim_now += span * $urandom_range(1, 6) + TIME_W'($urandom) % span;
        else if (pick < 70)
            stim_now += TIME_W'(pred_late) + $urandom_range(0, 3);
        else if (pick < 78)
        begin
            if (pred_late > 8)
                stim_now += TIME_W'(pred_late) - $urandom_range(1, 8);
        end
        else if (pick < 84)
            stim_now = {$urandom, $urandom};
        else if (pick < 90)
            stim_now -= $urandom_range(1, 100);
        else
            stim_now += span - $urandom_range(0, 1);
        r.now_ns = stim_now;
        return r;
    endfunction

    // Input driver: presents queued items and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic bus_busy;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            bus_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                grant_q.push_back(predict_grant(req_q[0]));
                void'(req_q.pop_front());
                bus_busy = 1'b0;
            end
            if (!bus_busy)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req_q[0].amount, req_q[0].now_ns};
                    s_axis_tuser  <= req_q[0].func;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random backpressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin : check_grants
        grant_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grant_q.size() == 0)
                begin
                    report_mismatch("output beat with no pending item");
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.granted)
                        report_mismatch($sformatf("granted %0d, want %0d",
                                                  m_axis_tdata[31:0], want.granted));
                    if (m_axis_tdata[63:32] !== want.wait_ns)
                        report_mismatch($sformatf("wait_ns %0d, want %0d",
                                                  m_axis_tdata[63:32], want.wait_ns));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_axis_tuser, want.status));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LATE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BLOCK_SAMPLES: pred_block  = value[BLOCK_W-1:0];
            REG_PERIOD_NS:     pred_period = value[PERIOD_W-1:0];
            REG_LATE_LIMIT_NS: pred_late   = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_req(input logic func, input logic [TIME_W-1:0] now_ns,
                            input logic [AMOUNT_W-1:0] amount);
        sample_req_t r;
        r.func   = func;
        r.now_ns = now_ns;
        r.amount = amount;
        req_q.push_back(r);
    endtask

    task automatic push_random(input int count);
        repeat (count) req_q.push_back(next_random_req());
    endtask

    // Registers change only once the block has drained.
    task automatic start_phase(input logic [BLOCK_W-1:0] block, input logic [PERIOD_W-1:0] period,
                               input logic [LATE_W-1:0] late, input int idle_pct,
                               input int stall_pct);
        wait_drained();
        write_reg(REG_BLOCK_SAMPLES, LATE_W'(block));
        write_reg(REG_PERIOD_NS, LATE_W'(period));
        write_reg(REG_LATE_LIMIT_NS, late);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset settings: period 1 ms, late limit 100 ms, 1024 samples.
        push_req(FUNC_REQUEST, 64'd0, 32'd100);
        push_req(FUNC_REQUEST, 64'd999999, 32'hFFFF_FFFF);
        push_req(FUNC_CONSUME, 64'd0, 32'hFFFF_FFFF);
        push_req(FUNC_REQUEST, 64'd500000, 32'd10);     // empty in period: refill and wait
        push_req(FUNC_CONSUME, 64'd0, 32'd0);
        push_req(FUNC_CONSUME, 64'd0, 32'd1);
        push_req(FUNC_REQUEST, 64'd2000000, 32'd0);     // exactly one period elapsed
        push_req(FUNC_REQUEST, 64'd101999999, 32'd5000); // just below the late limit
        push_req(FUNC_REQUEST, 64'd201000000, 32'd3);   // exactly at the late limit
        push_req(FUNC_REQUEST, 64'd0, 32'd1);           // time before the period start
        push_req(FUNC_REQUEST, '1, 32'hFFFF_FFFF);
        push_req(FUNC_CONSUME, '1, 32'hFFFF_FFFF);
        push_req(FUNC_REQUEST, '1, 32'd7);              // in period with the period start at the top of the time range
        push_req(FUNC_REQUEST, 64'd1999999, 32'd7);

        start_phase(32'd1, 32'd1000, 40'd20000, 75, 0);
        push_random(RANDOM_PER_PHASE);

        // Huge refills with a one-ns period drive the credit into saturation.
        start_phase(32'hFFFF_FFFF, 32'd1, 40'hFF_FFFF_FFFF, 0, 75);
        push_random(RANDOM_PER_PHASE);

        wait_drained();
        write_reg(REG_UNUSED, 40'hFF_FFFF_FFFF);
        start_phase(32'd0, 32'd0, 40'd1, 14, 14);
        push_random(RANDOM_PER_PHASE);

        start_phase(32'd300, 32'hFFFF_FFFF, 40'h05_0000_0000, 0, 0);
        push_random(RANDOM_PER_PHASE);

        start_phase(32'd7, 32'd50, 40'd1000, 14, 14);
        push_random(RANDOM_PER_PHASE / 2);
        wait_drained();
        push_random(RANDOM_PER_PHASE / 2);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
